// ===== rtl/core/anb_pkg.sv =====
package anb_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int OFFSET_BITS = 32;
  localparam int COUNT_BITS  = LENGTH_BITS + 1;

  localparam int INDEX_W      = 32;
  localparam int OFFSET_OUT_W = 32;
  localparam int LEN_OUT_W    = 24;
  localparam int PREFIX_W     = 3;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] LEN_MAX = {1'b0, {LENGTH_BITS{1'b1}}};

  localparam logic [PREFIX_W-1:0] PREFIX_NONE  = 3'd0;
  localparam logic [PREFIX_W-1:0] PREFIX_SHORT = 3'd3;
  localparam logic [PREFIX_W-1:0] PREFIX_LONG  = 3'd4;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  localparam logic STATUS_UNIT     = 1'b0;
  localparam logic STATUS_NO_START = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_UNIT = 3'b010,
    PH_HALT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic                    status;
    logic [INDEX_W-1:0]      unit_index;
    logic [OFFSET_OUT_W-1:0] unit_offset;
    logic [PREFIX_W-1:0]     prefix_length;
    logic [LEN_OUT_W-1:0]    unit_length;
    logic                    length_saturated;
    logic                    forbidden_zero_bit;
    logic [1:0]              ref_idc;
    logic [4:0]              unit_type;
    logic                    final_unit;
  } record_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== rtl/core/anb_in_stage.sv =====
module anb_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           end_of_stream,
  input  logic           take,
  output logic           item_valid,
  output anb_pkg::item_t item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte     <= data_byte;
      item.end_of_stream <= end_of_stream;
    end
  end

endmodule

// ===== rtl/core/anb_scan.sv =====
module anb_scan (
  input  logic               clk,
  input  logic               rst,
  input  anb_pkg::stage_ctl_t ctl,
  input  anb_pkg::item_t     item,
  output logic               emit,
  output anb_pkg::record_t   rec
);

  anb_pkg::phase_t                     phase, phase_next;
  logic [23:0]                         byte_history, byte_history_next;
  logic [1:0]                          hunt_count, hunt_count_next;
  logic [anb_pkg::PREFIX_W-1:0]        current_prefix, current_prefix_next;
  logic [anb_pkg::COUNT_BITS-1:0]      byte_count, byte_count_next;
  logic [7:0]                          header_byte, header_byte_next;
  logic [anb_pkg::INDEX_W-1:0]         units_seen, units_seen_next;
  logic [anb_pkg::OFFSET_BITS-1:0]     stream_position, stream_position_next;
  logic [anb_pkg::OFFSET_BITS-1:0]     current_start, current_start_next;

  logic [7:0]                          b;
  logic                                eos;
  logic [anb_pkg::COUNT_BITS-1:0]      bc_inc;
  logic [7:0]                          hdr_eff;
  logic                                m4;
  logic                                m3;
  logic [anb_pkg::PREFIX_W-1:0]        close_plen;
  logic [anb_pkg::COUNT_BITS-1:0]      len_close;
  logic [anb_pkg::COUNT_BITS-1:0]      len_raw;
  logic                                len_sat;
  logic [anb_pkg::LENGTH_BITS-1:0]     len_clip;
  logic [anb_pkg::PREFIX_W-1:0]        hunt_plen;
  logic                                hunt_bad;
  logic                                result;

  assign b   = item.data_byte;
  assign eos = item.end_of_stream;

  assign bc_inc  = (byte_count < anb_pkg::CNT_MAX) ? byte_count + 1'b1 : byte_count;
  assign hdr_eff = (byte_count == '0) ? b : header_byte;
  assign m4 = (byte_history == 24'd0) && (b == anb_pkg::BYTE_ONE);
  assign m3 = !m4 && (byte_history[15:0] == 16'd0) && (b == anb_pkg::BYTE_ONE);
  assign close_plen = m4 ? anb_pkg::PREFIX_LONG : anb_pkg::PREFIX_SHORT;
  assign len_close = (bc_inc >= anb_pkg::COUNT_BITS'(close_plen))
                     ? bc_inc - anb_pkg::COUNT_BITS'(close_plen) : '0;
  assign len_raw  = (m4 || m3) ? len_close : bc_inc;
  assign len_sat  = len_raw > anb_pkg::LEN_MAX;
  assign len_clip = len_sat ? anb_pkg::LEN_MAX[anb_pkg::LENGTH_BITS-1:0]
                            : len_raw[anb_pkg::LENGTH_BITS-1:0];

  always_comb begin
    hunt_plen = anb_pkg::PREFIX_NONE;
    hunt_bad  = 1'b0;
    hunt_count_next = hunt_count;
    case (hunt_count)
      2'd0, 2'd1: begin
        if (b == anb_pkg::BYTE_ZERO) begin
          hunt_count_next = hunt_count + 2'd1;
        end else begin
          hunt_bad = 1'b1;
        end
      end
      2'd2: begin
        if (b == anb_pkg::BYTE_ONE) begin
          hunt_plen = anb_pkg::PREFIX_SHORT;
        end else if (b == anb_pkg::BYTE_ZERO) begin
          hunt_count_next = 2'd3;
        end else begin
          hunt_bad = 1'b1;
        end
      end
      default: begin
        if (b == anb_pkg::BYTE_ONE) begin
          hunt_plen = anb_pkg::PREFIX_LONG;
        end else begin
          hunt_bad = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    phase_next           = phase;
    byte_history_next    = byte_history;
    current_prefix_next  = current_prefix;
    byte_count_next      = byte_count;
    header_byte_next     = header_byte;
    units_seen_next      = units_seen;
    stream_position_next = stream_position;
    current_start_next   = current_start;
    result               = 1'b0;
    rec                  = '0;
    unique case (phase)
      anb_pkg::PH_HUNT: begin
        stream_position_next = stream_position + 1'b1;
        byte_history_next    = {byte_history[15:0], b};
        if (hunt_plen != anb_pkg::PREFIX_NONE) begin
          current_prefix_next = hunt_plen;
          current_start_next  = stream_position
                                - anb_pkg::OFFSET_BITS'(hunt_plen - 3'd1);
          byte_count_next     = '0;
          header_byte_next    = '0;
          phase_next          = eos ? anb_pkg::PH_HALT : anb_pkg::PH_UNIT;
        end else if (hunt_bad || eos) begin
          result     = 1'b1;
          rec.status = anb_pkg::STATUS_NO_START;
          phase_next = anb_pkg::PH_HALT;
        end
      end
      anb_pkg::PH_UNIT: begin
        stream_position_next = stream_position + 1'b1;
        byte_history_next    = {byte_history[15:0], b};
        byte_count_next      = bc_inc;
        header_byte_next     = hdr_eff;
        rec.unit_index       = units_seen;
        rec.unit_offset      = anb_pkg::OFFSET_OUT_W'(current_start);
        rec.prefix_length    = current_prefix;
        rec.unit_length      = anb_pkg::LEN_OUT_W'(len_clip);
        rec.length_saturated = len_sat;
        if (len_clip != '0) begin
          rec.forbidden_zero_bit = hdr_eff[7];
          rec.ref_idc            = hdr_eff[6:5];
          rec.unit_type          = hdr_eff[4:0];
        end
        rec.final_unit = eos;
        if (m4 || m3) begin
          result              = 1'b1;
          units_seen_next     = units_seen + 1'b1;
          current_prefix_next = close_plen;
          current_start_next  = stream_position
                                - anb_pkg::OFFSET_BITS'(close_plen - 3'd1);
          byte_count_next     = '0;
          header_byte_next    = '0;
          phase_next          = eos ? anb_pkg::PH_HALT : anb_pkg::PH_UNIT;
        end else if (eos) begin
          result          = 1'b1;
          units_seen_next = units_seen + 1'b1;
          phase_next      = anb_pkg::PH_HALT;
        end
      end
      default: begin
        phase_next = anb_pkg::PH_HALT;
      end
    endcase
  end

  assign emit = ctl.valid && result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= anb_pkg::PH_HUNT;
      byte_history    <= '0;
      hunt_count      <= '0;
      current_prefix  <= '0;
      byte_count      <= '0;
      header_byte     <= '0;
      units_seen      <= '0;
      stream_position <= '0;
      current_start   <= '0;
    end else if (ctl.take) begin
      phase           <= phase_next;
      byte_history    <= byte_history_next;
      hunt_count      <= hunt_count_next;
      current_prefix  <= current_prefix_next;
      byte_count      <= byte_count_next;
      header_byte     <= header_byte_next;
      units_seen      <= units_seen_next;
      stream_position <= stream_position_next;
      current_start   <= current_start_next;
    end
  end

`ifndef ASSERT_OFF
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == anb_pkg::PH_HALT) |-> !emit)
    else $error("A record was produced after the parser halted.");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && emit && !rec.status) |=> (units_seen == $past(units_seen) + 1'b1))
    else $error("The unit index did not advance after a unit record.");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && emit && rec.status) |=> (phase == anb_pkg::PH_HALT))
    else $error("The parser did not halt after an error record.");
`endif

endmodule

// ===== rtl/core/anb_out_stage.sv =====
module anb_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  anb_pkg::record_t rec_in,
  input  logic             out_ready,
  output logic             can_load,
  output logic             out_valid,
  output anb_pkg::record_t rec
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rec <= rec_in;
    end
  end

endmodule

// ===== rtl/core/annexb_nal_unit_delimiter_top.sv =====
// Splits an H.264 Annex B byte stream into units, one byte per clock cycle
// sustained; an accepted byte is held in the input register, and the scan logic
// then writes the record that the byte closes into the result register.
// The stream must open with a three or four byte start code; otherwise a single
// error record is given and the block ignores all further bytes until reset.
// Each unit record is given when the next start code completes or when the byte
// marked end of stream arrives; an empty unit after a start code on the final
// byte is not reported. The one-byte rate is set by the scan state update,
// which is combinational logic, and holds while the result side takes records.
module annexb_nal_unit_delimiter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [31:0] unit_index,
  output logic [31:0] unit_offset,
  output logic [2:0]  prefix_length,
  output logic [23:0] unit_length,
  output logic        length_saturated,
  output logic        forbidden_zero_bit,
  output logic [1:0]  ref_idc,
  output logic [4:0]  unit_type,
  output logic        final_unit
);

  anb_pkg::item_t      item;
  anb_pkg::stage_ctl_t ctl;
  anb_pkg::record_t    scan_rec;
  anb_pkg::record_t    rec;
  logic                item_valid;
  logic                can_load;
  logic                emit;

  assign ctl.valid = item_valid;
  assign ctl.take  = item_valid && can_load;

  anb_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .take          (ctl.take),
    .item_valid    (item_valid),
    .item          (item)
  );

  anb_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .item (item),
    .emit (emit),
    .rec  (scan_rec)
  );

  anb_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .rec_in    (scan_rec),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .rec       (rec)
  );

  assign status             = rec.status;
  assign unit_index         = rec.unit_index;
  assign unit_offset        = rec.unit_offset;
  assign prefix_length      = rec.prefix_length;
  assign unit_length        = rec.unit_length;
  assign length_saturated   = rec.length_saturated;
  assign forbidden_zero_bit = rec.forbidden_zero_bit;
  assign ref_idc            = rec.ref_idc;
  assign unit_type          = rec.unit_type;
  assign final_unit         = rec.final_unit;

endmodule
